// ===== sv/iass_pkg.sv =====
// Shared types and constants for the index append and strip stitching block.
package iass_pkg;

  localparam int WORD_W = 32;
  localparam int INDEX_BITS_DEF = 32;
  localparam int RUN_MAX = 3;
  localparam int CNT_W = $clog2(RUN_MAX + 1);

  localparam logic [CNT_W-1:0] RUN_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] RUN_FULL = CNT_W'(RUN_MAX);
  localparam logic [CNT_W-1:0] RUN_NONE = CNT_W'(0);

  typedef struct packed {
    logic [WORD_W-1:0] source_index;
    logic [WORD_W-1:0] vertex_offset;
    logic              instance_start;
    logic              buffer_start;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_index;
    logic              last_of_run;
  } out_word_t;

  // Results caused by one input word, slot 0 goes out first.
  typedef struct packed {
    logic [RUN_MAX-1:0][WORD_W-1:0] idx;
    logic [CNT_W-1:0]               cnt;
  } run_t;

endpackage

// ===== sv/iass_stitch.sv =====
// Offset add, stitch decision and stitch state for one input word.
module iass_stitch #(
  parameter int INDEX_BITS = iass_pkg::INDEX_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             strip_mode,
  input  logic             take,
  input  iass_pkg::in_word_t item,
  output iass_pkg::run_t   run
);

  logic                  buffer_nonempty;
  logic                  stitching_active;
  logic [INDEX_BITS-1:0] last_emitted;
  logic [INDEX_BITS-1:0] held_first;

  logic                  stitching_active_next;
  logic                  held_load;
  logic [INDEX_BITS-1:0] v;
  logic                  nonempty_eff;
  logic                  owed_eff;
  logic [iass_pkg::WORD_W-1:0] v_w;

  assign v = item.source_index[INDEX_BITS-1:0] + item.vertex_offset[INDEX_BITS-1:0];
  assign v_w = iass_pkg::WORD_W'(v);
  assign nonempty_eff = buffer_nonempty && !item.buffer_start;
  assign owed_eff = stitching_active && !item.buffer_start && !item.instance_start;

  always_comb begin
    run.idx = {iass_pkg::RUN_MAX{v_w}};
    run.cnt = iass_pkg::RUN_ONE;
    stitching_active_next = 1'b0;
    held_load = 1'b0;
    priority if (!strip_mode) begin
      run.cnt = iass_pkg::RUN_ONE;
    end else if (item.instance_start && nonempty_eff) begin
      // first half: last, s0, s0
      run.idx[0] = iass_pkg::WORD_W'(last_emitted);
      run.cnt = iass_pkg::RUN_FULL;
      stitching_active_next = 1'b1;
      held_load = 1'b1;
    end else if (owed_eff) begin
      // second half: s1, s0, s1
      run.idx[1] = iass_pkg::WORD_W'(held_first);
      run.cnt = iass_pkg::RUN_FULL;
    end else begin
      run.cnt = iass_pkg::RUN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_nonempty <= 1'b0;
      stitching_active <= 1'b0;
      last_emitted <= '0;
      held_first <= '0;
    end else if (take) begin
      buffer_nonempty <= 1'b1;
      stitching_active <= stitching_active_next;
      last_emitted <= v;
      if (held_load) begin
        held_first <= v;
      end
    end
  end

endmodule

// ===== sv/iass_run_buf.sv =====
// Result register: holds one run of results and shifts them out one per word.
module iass_run_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  iass_pkg::run_t      run,
  input  logic                out_stall,
  output logic                out_valid,
  output iass_pkg::out_word_t out_word,
  output logic                can_load
);

  logic [iass_pkg::RUN_MAX-1:0][iass_pkg::WORD_W-1:0] slots;
  logic [iass_pkg::CNT_W-1:0]                         remaining;
  logic                                               out_take;

  assign out_valid = (remaining != iass_pkg::RUN_NONE);
  assign out_take = out_valid && !out_stall;
  assign out_word.out_index = slots[0];
  assign out_word.last_of_run = (remaining == iass_pkg::RUN_ONE);
  assign can_load = !out_valid || (out_take && remaining == iass_pkg::RUN_ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= iass_pkg::RUN_NONE;
    end else if (load) begin
      remaining <= run.cnt;
    end else if (out_take) begin
      remaining <= remaining - iass_pkg::RUN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= run.idx;
    end else if (out_take) begin
      for (int i = 0; i < iass_pkg::RUN_MAX - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

endmodule

// ===== sv/index_append_strip_stitcher.sv =====
// Top level of the index append and strip stitching block.
//
//   channel   valid      stall      payload                  direction
//   input     in_valid   in_stall   in_word  (in_word_t)     into block
//   output    out_valid  out_stall  out_word (out_word_t)    out of block
//   config    cfg_write  -          cfg_data (strip_mode)    into block
//
// A word passes through the input register, then lands as a run of one or
// three results in the result register. Single-result words sustain one word
// per cycle while the output does not stall; a three-result stitch word keeps
// the result register until all three results have left through the
// one-result-per-cycle output port, so the word behind it waits. Reset
// (synchronous, rst high) clears strip_mode, the stitch state and both valid
// flags. A stall on the output holds the current result and backs up into
// in_stall once the input register is full.
module index_append_strip_stitcher #(
  parameter int INDEX_BITS = iass_pkg::INDEX_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  iass_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output iass_pkg::out_word_t out_word
);

  logic               strip_mode;
  logic               item_valid;
  iass_pkg::in_word_t item;
  iass_pkg::run_t     run;
  logic               can_load;
  logic               take;

  // Hand the registered word to the result register once it has room.
  assign take = item_valid && can_load;
  // Stall upstream only while the input register is full and cannot drain.
  assign in_stall = item_valid && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_mode <= 1'b0;
    end else if (cfg_write) begin
      strip_mode <= cfg_data;
    end
  end

  // Input register: advance on accept, drop valid when drained with nothing new.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_word;
    end
  end

  iass_stitch #(
    .INDEX_BITS(INDEX_BITS)
  ) u_stitch (
    .clk(clk),
    .rst(rst),
    .strip_mode(strip_mode),
    .take(take),
    .item(item),
    .run(run)
  );

  iass_run_buf u_run_buf (
    .clk(clk),
    .rst(rst),
    .load(take),
    .run(run),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_word(out_word),
    .can_load(can_load)
  );

endmodule
